### rtl/rrs_pkg.sv
// ----------------------------------------------------------------------------
// rrs_pkg
// Shared widths, codes and types of the round-robin task scheduler.
// ----------------------------------------------------------------------------
package rrs_pkg;

    localparam int SLOTS_DEFAULT   = 32;
    localparam int ID_W            = 16;
    localparam int QUANT_W         = 8;
    localparam int OP_W            = 2;
    localparam int STATUS_W        = 2;
    localparam int TASK_COUNT_W    = 6;
    localparam int DATA_W          = ID_W + QUANT_W;

    localparam logic [QUANT_W-1:0] QUANTUM_DEFAULT = QUANT_W'(10);

    typedef enum logic [OP_W-1:0] {
        OP_LOAD = 2'd0,
        OP_EXIT = 2'd1,
        OP_TICK = 2'd2
    } rrs_op_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK         = 2'd0,
        STAT_FULL       = 2'd1,
        STAT_ZERO_ID    = 2'd2,
        STAT_NO_CURRENT = 2'd3
    } rrs_status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_LD_TAIL,
        S_LD_HEAD_RD,
        S_LD_HEAD,
        S_EX_LINK,
        S_EX_PREV,
        S_EX_NEXT_RD,
        S_EX_NEXT,
        S_TICK,
        S_FETCH,
        S_DONE
    } rrs_state_t;

endpackage

### rtl/rrs_if.sv
// ----------------------------------------------------------------------------
// rrs_if
// Valid/ready channels of the scheduler: request, result and register write.
// ----------------------------------------------------------------------------
interface rrs_req_if;
    logic                         valid;
    logic                         ready;
    logic [rrs_pkg::OP_W-1:0]     operation;
    logic [rrs_pkg::ID_W-1:0]     task_id;

    modport source (output valid, output operation, output task_id, input ready);
    modport sink   (input valid, input operation, input task_id, output ready);
endinterface

interface rrs_res_if;
    logic                             valid;
    logic                             ready;
    logic [rrs_pkg::ID_W-1:0]         running_id;
    logic [rrs_pkg::STATUS_W-1:0]     status;
    logic [rrs_pkg::TASK_COUNT_W-1:0] task_count;

    modport source (output valid, output running_id, output status, output task_count,
                    input ready);
    modport sink   (input valid, input running_id, input status, input task_count,
                    output ready);
endinterface

interface rrs_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [rrs_pkg::QUANT_W-1:0]  quantum_reload;

    modport source (output valid, output quantum_reload, input ready);
    modport sink   (input valid, input quantum_reload, output ready);
endinterface

### rtl/rrs_ram.sv
// ----------------------------------------------------------------------------
// rrs_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module rrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### rtl/rrs_free_find.sv
// ----------------------------------------------------------------------------
// rrs_free_find
// Lowest free slot of the occupancy map, and a flag when none is free.
// ----------------------------------------------------------------------------
module rrs_free_find #(
    parameter int SLOTS = 32
) (
    input  logic [SLOTS-1:0]         occupied,
    output logic [$clog2(SLOTS)-1:0] free_slot,
    output logic                     full
);

    localparam int IW = $clog2(SLOTS);

    logic [SLOTS-1:0] lowest_free;

    // isolate the lowest clear bit: the carry of +1 stops there
    assign lowest_free = ~occupied & (occupied + SLOTS'(1));
    assign full        = &occupied;

    always_comb
    begin
        free_slot = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            free_slot = free_slot | (lowest_free[i] ? IW'(i) : '0);
        end
    end

endmodule

### rtl/round_robin_task_scheduler.sv
// ----------------------------------------------------------------------------
// round_robin_task_scheduler
// Sequence: a request runs S_DECODE, S_FETCH and S_DONE for a rejected load,
//   a load into an empty ring, a tick or an exit with no current task, an
//   exit with at most one task or an unused code; a tick on a current task
//   adds S_TICK, a load into a non-empty ring S_LD_TAIL to S_LD_HEAD, an exit
//   from a longer ring S_EX_LINK to S_EX_NEXT (link RAM read-modify-write).
// One request in work at a time; a waiting result holds the next one in S_DONE.
// Reset: control and occupancy flops clear at once; no clearing pass.
// ----------------------------------------------------------------------------
module round_robin_task_scheduler #(
    parameter int SLOTS = rrs_pkg::SLOTS_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    rrs_req_if.sink    request,
    rrs_res_if.source  result,
    rrs_cfg_if.sink    cfg
);

    import rrs_pkg::*;

    localparam int IW = $clog2(SLOTS);      // slot index width
    localparam int CW = $clog2(SLOTS + 1);  // ring count width
    localparam int LW = 2 * IW;             // link entry: {next, prev}

    // ------------------------------------------------------------------
    // State registers
    // ------------------------------------------------------------------
    rrs_state_t           state_reg, state_next;
    rrs_op_t              op_reg, op_next;
    logic [ID_W-1:0]      id_reg, id_next;
    rrs_status_t          status_reg, status_next;
    logic [QUANT_W-1:0]   quantum_reg;

    logic [SLOTS-1:0]     occ_reg, occ_next;       // slot in use
    logic [IW-1:0]        free_reg;                // lowest free slot, tracked
    logic                 full_reg;
    logic [IW-1:0]        slot_reg, slot_next;     // slot being loaded
    logic [IW-1:0]        head_reg, head_next;
    logic [IW-1:0]        tail_reg, tail_next;
    logic [IW-1:0]        cur_reg, cur_next;
    logic                 cur_valid_reg, cur_valid_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [IW-1:0]        n_reg, n_next;           // successor of exiting task
    logic [IW-1:0]        p_reg, p_next;           // predecessor of exiting task

    logic                    out_valid_reg, out_valid_next;
    logic [ID_W-1:0]         out_id_reg, out_id_next;
    rrs_status_t             out_status_reg, out_status_next;
    logic [TASK_COUNT_W-1:0] out_count_reg, out_count_next;

    // ------------------------------------------------------------------
    // Memories: task data {id, quantum} and ring links {next, prev}
    // ------------------------------------------------------------------
    logic              data_wr_en, data_rd_en;
    logic [IW-1:0]     data_wr_addr, data_rd_addr;
    logic [DATA_W-1:0] data_wr_data, data_rd_data;
    logic              link_wr_en, link_rd_en;
    logic [IW-1:0]     link_wr_addr, link_rd_addr;
    logic [LW-1:0]     link_wr_data, link_rd_data;

    logic [ID_W-1:0]    rd_id;
    logic [QUANT_W-1:0] rd_quant;
    logic [IW-1:0]      rd_next, rd_prev;

    logic [IW-1:0] free_slot;
    logic          full;
    logic          in_accept;
    logic          out_free;

    rrs_ram #(.WIDTH(DATA_W), .DEPTH(SLOTS)) u_data_ram (
        .clk     (clk),
        .wr_en   (data_wr_en),
        .wr_addr (data_wr_addr),
        .wr_data (data_wr_data),
        .rd_en   (data_rd_en),
        .rd_addr (data_rd_addr),
        .rd_data (data_rd_data)
    );

    rrs_ram #(.WIDTH(LW), .DEPTH(SLOTS)) u_link_ram (
        .clk     (clk),
        .wr_en   (link_wr_en),
        .wr_addr (link_wr_addr),
        .wr_data (link_wr_data),
        .rd_en   (link_rd_en),
        .rd_addr (link_rd_addr),
        .rd_data (link_rd_data)
    );

    rrs_free_find #(.SLOTS(SLOTS)) u_free_find (
        .occupied  (occ_reg),
        .free_slot (free_slot),
        .full      (full)
    );

    assign rd_id    = data_rd_data[DATA_W-1 -: ID_W];
    assign rd_quant = data_rd_data[QUANT_W-1:0];
    assign rd_next  = link_rd_data[LW-1 -: IW];
    assign rd_prev  = link_rd_data[IW-1:0];

    // ------------------------------------------------------------------
    // Handshakes: one request in flight; the output register holds a
    // finished result so the next request can be taken meanwhile
    // ------------------------------------------------------------------
    assign request.ready = (state_reg == S_IDLE);
    assign in_accept     = request.valid && request.ready;
    assign out_free      = !out_valid_reg || result.ready;
    assign cfg.ready     = 1'b1;

    assign result.valid      = out_valid_reg;
    assign result.running_id = out_id_reg;
    assign result.status     = out_status_reg;
    assign result.task_count = out_count_reg;

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (op_reg)
                    OP_LOAD:
                    begin
                        if (id_reg == '0 || full_reg || count_reg == '0)
                        begin
                            state_next = S_FETCH;
                        end
                        else
                        begin
                            state_next = S_LD_TAIL;
                        end
                    end
                    OP_EXIT:
                    begin
                        if (!cur_valid_reg || count_reg <= CW'(1))
                        begin
                            state_next = S_FETCH;
                        end
                        else
                        begin
                            state_next = S_EX_LINK;
                        end
                    end
                    OP_TICK:
                    begin
                        state_next = cur_valid_reg ? S_TICK : S_FETCH;
                    end
                    default:
                    begin
                        state_next = S_FETCH;
                    end
                endcase
            end
            S_LD_TAIL:    state_next = S_LD_HEAD_RD;
            S_LD_HEAD_RD: state_next = S_LD_HEAD;
            S_LD_HEAD:    state_next = S_FETCH;
            S_EX_LINK:    state_next = S_EX_PREV;
            S_EX_PREV:    state_next = S_EX_NEXT_RD;
            S_EX_NEXT_RD: state_next = S_EX_NEXT;
            S_EX_NEXT:    state_next = S_FETCH;
            S_TICK:       state_next = S_FETCH;
            S_FETCH:      state_next = S_DONE;
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:      state_next = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath and memory control per state
    // ------------------------------------------------------------------
    always_comb
    begin
        op_next         = op_reg;
        id_next         = id_reg;
        status_next     = status_reg;
        occ_next        = occ_reg;
        slot_next       = slot_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        cur_next        = cur_reg;
        cur_valid_next  = cur_valid_reg;
        count_next      = count_reg;
        n_next          = n_reg;
        p_next          = p_reg;
        out_valid_next  = out_valid_reg;
        out_id_next     = out_id_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;

        data_wr_en   = 1'b0;
        data_wr_addr = '0;
        data_wr_data = '0;
        data_rd_en   = 1'b0;
        data_rd_addr = '0;
        link_wr_en   = 1'b0;
        link_wr_addr = '0;
        link_wr_data = '0;
        link_rd_en   = 1'b0;
        link_rd_addr = '0;

        // drop the result once the sink has taken it
        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    op_next     = rrs_op_t'(request.operation);
                    id_next     = request.task_id;
                    status_next = STAT_OK;
                end
            end
            S_DECODE:
            begin
                unique case (op_reg)
                    OP_LOAD:
                    begin
                        if (id_reg == '0)
                        begin
                            status_next = STAT_ZERO_ID;
                        end
                        else if (full_reg)
                        begin
                            status_next = STAT_FULL;
                        end
                        else
                        begin
                            // write the new entry, link it in front of head
                            // and behind tail; patch the neighbours next
                            data_wr_en   = 1'b1;
                            data_wr_addr = free_reg;
                            data_wr_data = {id_reg, quantum_reg};
                            link_wr_en   = 1'b1;
                            link_wr_addr = free_reg;
                            occ_next[free_reg] = 1'b1;
                            count_next   = count_reg + CW'(1);
                            slot_next    = free_reg;
                            if (count_reg == '0)
                            begin
                                link_wr_data = {free_reg, free_reg};
                                head_next    = free_reg;
                                tail_next    = free_reg;
                            end
                            else
                            begin
                                link_wr_data = {head_reg, tail_reg};
                                link_rd_en   = 1'b1;
                                link_rd_addr = tail_reg;
                            end
                        end
                    end
                    OP_EXIT:
                    begin
                        if (!cur_valid_reg || count_reg == '0)
                        begin
                            status_next = STAT_NO_CURRENT;
                        end
                        else if (count_reg == CW'(1))
                        begin
                            // last task leaves: ring becomes empty
                            occ_next[cur_reg] = 1'b0;
                            head_next      = '0;
                            tail_next      = '0;
                            cur_next       = '0;
                            cur_valid_next = 1'b0;
                            count_next     = count_reg - CW'(1);
                        end
                        else
                        begin
                            link_rd_en   = 1'b1;
                            link_rd_addr = cur_reg;
                        end
                    end
                    OP_TICK:
                    begin
                        if (!cur_valid_reg)
                        begin
                            if (count_reg != '0)
                            begin
                                cur_next       = head_reg;
                                cur_valid_next = 1'b1;
                            end
                        end
                        else
                        begin
                            data_rd_en   = 1'b1;
                            data_rd_addr = cur_reg;
                            link_rd_en   = 1'b1;
                            link_rd_addr = cur_reg;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_LD_TAIL:
            begin
                link_wr_en   = 1'b1;
                link_wr_addr = tail_reg;
                link_wr_data = {slot_reg, rd_prev};
            end
            S_LD_HEAD_RD:
            begin
                // read after the tail write so head == tail sees it
                link_rd_en   = 1'b1;
                link_rd_addr = head_reg;
            end
            S_LD_HEAD:
            begin
                link_wr_en   = 1'b1;
                link_wr_addr = head_reg;
                link_wr_data = {rd_next, slot_reg};
                tail_next    = slot_reg;
            end
            S_EX_LINK:
            begin
                n_next       = rd_next;
                p_next       = rd_prev;
                link_rd_en   = 1'b1;
                link_rd_addr = rd_prev;
            end
            S_EX_PREV:
            begin
                link_wr_en   = 1'b1;
                link_wr_addr = p_reg;
                link_wr_data = {n_reg, rd_prev};
            end
            S_EX_NEXT_RD:
            begin
                link_rd_en   = 1'b1;
                link_rd_addr = n_reg;
            end
            S_EX_NEXT:
            begin
                link_wr_en   = 1'b1;
                link_wr_addr = n_reg;
                link_wr_data = {rd_next, p_reg};
                if (head_reg == cur_reg)
                begin
                    head_next = n_reg;
                end
                if (tail_reg == cur_reg)
                begin
                    tail_next = p_reg;
                end
                occ_next[cur_reg] = 1'b0;
                cur_next   = n_reg;
                count_next = count_reg - CW'(1);
            end
            S_TICK:
            begin
                // spend one tick of quantum, or reload and advance
                data_wr_en   = 1'b1;
                data_wr_addr = cur_reg;
                if (rd_quant != '0)
                begin
                    data_wr_data = {rd_id, rd_quant - QUANT_W'(1)};
                end
                else
                begin
                    data_wr_data = {rd_id, quantum_reg};
                    cur_next     = rd_next;
                end
            end
            S_FETCH:
            begin
                data_rd_en   = 1'b1;
                data_rd_addr = cur_reg;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_id_next     = cur_valid_reg ? rd_id : '0;
                    out_status_next = status_reg;
                    out_count_next  = TASK_COUNT_W'(count_reg);
                end
            end
            default:
            begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            quantum_reg   <= QUANTUM_DEFAULT;
            occ_reg       <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            cur_reg       <= '0;
            cur_valid_reg <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            cur_reg       <= cur_next;
            cur_valid_reg <= cur_valid_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                quantum_reg <= cfg.quantum_reload;
            end
        end
    end

    // payload: no reset
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        id_reg         <= id_next;
        status_reg     <= status_next;
        slot_reg       <= slot_next;
        n_reg          <= n_next;
        p_reg          <= p_next;
        out_id_reg     <= out_id_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
        // track the lowest free slot; stable while a request is decoded
        free_reg       <= free_slot;
        full_reg       <= full;
    end

endmodule

### rtl/rrs_checker.sv
// ----------------------------------------------------------------------------
// rrs_checker
// Port-level checks of the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module rrs_checker #(
    parameter int SLOTS = rrs_pkg::SLOTS_DEFAULT
) (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_ready,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic [rrs_pkg::ID_W-1:0]         out_running_id,
    input logic [rrs_pkg::STATUS_W-1:0]     out_status,
    input logic [rrs_pkg::TASK_COUNT_W-1:0] out_task_count
);

    import rrs_pkg::*;

    logic [1:0]              pend_reg, pend_next;
    logic [TASK_COUNT_W-1:0] last_count_reg;
    logic                    in_acc, out_acc;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    always_comb
    begin
        pend_next = pend_reg;
        if (in_acc && !out_acc)
        begin
            pend_next = pend_reg + 2'd1;
        end
        else if (!in_acc && out_acc)
        begin
            pend_next = pend_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg       <= '0;
            last_count_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
            if (out_acc)
            begin
                last_count_reg <= out_task_count;
            end
        end
    end

    // at most one request in work and one result waiting
    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg != 2'd3)
        else $error("more requests outstanding than the scheduler can hold");

    // one request adds or removes at most one task
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_task_count == last_count_reg)
                   || (out_task_count == last_count_reg + TASK_COUNT_W'(1))
                   || (out_task_count + TASK_COUNT_W'(1) == last_count_reg))
        else $error("task count jumped by more than one");

    // an empty ring has no running task
    a_empty_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_task_count == '0) |-> out_running_id == '0)
        else $error("running id reported with an empty ring");

    // a full rejection only with every slot taken
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_status == STAT_FULL) |-> out_task_count == TASK_COUNT_W'(SLOTS))
        else $error("table full reported with free slots");

    // hold a stalled result
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid && $stable(out_running_id)
                                      && $stable(out_status) && $stable(out_task_count))
        else $error("stalled result changed");

endmodule

bind round_robin_task_scheduler rrs_checker #(.SLOTS(SLOTS)) u_rrs_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (request.valid),
    .in_ready       (request.ready),
    .out_valid      (result.valid),
    .out_ready      (result.ready),
    .out_running_id (result.running_id),
    .out_status     (result.status),
    .out_task_count (result.task_count)
);

### test/tb_round_robin_task_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_round_robin_task_scheduler
// Self-checking bench for the round-robin task scheduler. Requests are driven
// on the falling edge and results are checked on the rising edge against a
// behavioural copy of the slot table and its ring. The run covers corner
// cases, quantum extremes, a full table, random traffic with idling on both
// sides, and a long result hold-off that backs up the request channel.
// ----------------------------------------------------------------------------
module tb_round_robin_task_scheduler;

    import rrs_pkg::*;

    localparam int SLOTS  = SLOTS_DEFAULT;
    localparam int SLOT_W = $clog2(SLOTS);

    // Operation code that the block must treat as a no-op.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // Settling time after the last result before a register write or the end.
    localparam int SETTLE_CYCLES = 12;
    localparam int MAX_REPORTS   = 10;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    typedef struct packed {
        logic [ID_W-1:0]         running_id;
        rrs_status_t             status;
        logic [TASK_COUNT_W-1:0] task_count;
    } sched_result_t;

    logic clk = 1'b0;
    logic rst_n;

    rrs_req_if req_ch ();
    rrs_res_if res_ch ();
    rrs_cfg_if cfg_ch ();

    round_robin_task_scheduler #(
        .SLOTS (SLOTS)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (req_ch),
        .result  (res_ch),
        .cfg     (cfg_ch)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------------
    // Scheduler shadow: slot table, ring links and the current pointer.
    // ------------------------------------------------------------------------
    logic [ID_W-1:0]    slot_task  [SLOTS];
    logic [QUANT_W-1:0] slot_ticks [SLOTS];
    logic [SLOT_W-1:0]  ring_next  [SLOTS];
    logic [SLOT_W-1:0]  ring_prev  [SLOTS];
    logic [SLOT_W-1:0]  run_slot;
    logic               run_valid;
    logic [SLOT_W-1:0]  ring_head;
    logic [SLOT_W-1:0]  ring_tail;
    int unsigned        ring_size;
    logic [QUANT_W-1:0] reload_ticks;

    sched_result_t pending_results[$];

    int mismatch_count = 0;
    int gap_pct        = 0;
    int stall_pct      = 0;
    int hold_off_cycles = 0;

    function automatic void clear_schedule();
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_task[i]  = '0;
            slot_ticks[i] = '0;
            ring_next[i]  = '0;
            ring_prev[i]  = '0;
        end
        run_slot     = '0;
        run_valid    = 1'b0;
        ring_head    = '0;
        ring_tail    = '0;
        ring_size    = 0;
        reload_ticks = QUANTUM_DEFAULT;
    endfunction

    // Link a new task at the tail of the ring in the lowest free slot.
    function automatic rrs_status_t admit_task(input logic [ID_W-1:0] id);
        int free_slot;
        logic [SLOT_W-1:0] s;
        free_slot = -1;
        if (id == '0)
            return STAT_ZERO_ID;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (slot_task[i] == '0)
                free_slot = i;
        end
        if (free_slot < 0)
            return STAT_FULL;
        s = SLOT_W'(free_slot);
        slot_task[s]  = id;
        slot_ticks[s] = reload_ticks;
        if (ring_size == 0)
        begin
            ring_next[s] = s;
            ring_prev[s] = s;
            ring_head    = s;
            ring_tail    = s;
        end
        else
        begin
            ring_next[s]         = ring_head;
            ring_prev[s]         = ring_tail;
            ring_next[ring_tail] = s;
            ring_prev[ring_head] = s;
            ring_tail            = s;
        end
        ring_size++;
        return STAT_OK;
    endfunction

    // Unlink the current task and hand the turn to its successor.
    function automatic rrs_status_t retire_current();
        logic [SLOT_W-1:0] c;
        logic [SLOT_W-1:0] n;
        logic [SLOT_W-1:0] p;
        if (!run_valid || ring_size == 0)
            return STAT_NO_CURRENT;
        c = run_slot;
        if (ring_size > 1)
        begin
            n = ring_next[c];
            p = ring_prev[c];
            if (ring_head == c)
                ring_head = n;
            if (ring_tail == c)
                ring_tail = p;
            ring_next[p] = n;
            ring_prev[n] = p;
            run_slot     = n;
        end
        else
        begin
            ring_head = '0;
            ring_tail = '0;
            run_slot  = '0;
            run_valid = 1'b0;
        end
        slot_task[c]  = '0;
        slot_ticks[c] = '0;
        ring_next[c]  = '0;
        ring_prev[c]  = '0;
        ring_size--;
        return STAT_OK;
    endfunction

    function automatic void timer_tick();
        if (!run_valid)
        begin
            if (ring_size != 0)
            begin
                run_slot  = ring_head;
                run_valid = 1'b1;
            end
        end
        else if (slot_ticks[run_slot] > 0)
            slot_ticks[run_slot]--;
        else
        begin
            slot_ticks[run_slot] = reload_ticks;
            run_slot             = ring_next[run_slot];
        end
    endfunction

    function automatic sched_result_t schedule_request(input logic [OP_W-1:0] op,
                                                       input logic [ID_W-1:0] id);
        sched_result_t r;
        r.status = STAT_OK;
        case (op)
            OP_LOAD: r.status = admit_task(id);
            OP_EXIT: r.status = retire_current();
            OP_TICK: timer_tick();
            default: ;
        endcase
        r.running_id = run_valid ? slot_task[run_slot] : '0;
        r.task_count = TASK_COUNT_W'(ring_size);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Result side: ready pattern and field-by-field checking.
    // ------------------------------------------------------------------------
    function automatic void note_mismatch(input string what, input int want, input int got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, want, got);
    endfunction

    // Drive ready on the falling edge; a hold-off overrides the random stalls.
    always @(negedge clk)
    begin
        if (hold_off_cycles > 0)
        begin
            res_ch.ready <= 1'b0;
            hold_off_cycles = hold_off_cycles - 1;
        end
        else
            res_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        sched_result_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending_results.size() == 0)
                note_mismatch("unexpected result, running_id", -1, res_ch.running_id);
            else
            begin
                want = pending_results.pop_front();
                if (res_ch.running_id !== want.running_id)
                    note_mismatch("running_id", want.running_id, res_ch.running_id);
                if (res_ch.status !== want.status)
                    note_mismatch("status", want.status, res_ch.status);
                if (res_ch.task_count !== want.task_count)
                    note_mismatch("task_count", want.task_count, res_ch.task_count);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Request side.
    // ------------------------------------------------------------------------
    function automatic void set_idling(input idle_mode_t mode);
        case (mode)
            IDLE_NONE:     begin gap_pct = 0;  stall_pct = 0;  end
            IDLE_SENDER:   begin gap_pct = 59; stall_pct = 0;  end
            IDLE_RECEIVER: begin gap_pct = 0;  stall_pct = 59; end
            default:       begin gap_pct = 14; stall_pct = 14; end
        endcase
    endfunction

    // Offer one request, hold it until taken, then record what it must yield.
    // Valid stays high between back-to-back requests; no falling edge sees more
    // than one assignment to it.
    task automatic send_request(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id);
        while (gap_pct != 0 && $urandom_range(99) < gap_pct)
        begin
            @(negedge clk);
            req_ch.valid <= 1'b0;
        end
        @(negedge clk);
        req_ch.valid     <= 1'b1;
        req_ch.operation <= op;
        req_ch.task_id   <= id;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        pending_results.push_back(schedule_request(op, id));
    endtask

    // Drop valid and wait for the block to drain before touching the register.
    task automatic settle_idle();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_quantum(input logic [QUANT_W-1:0] ticks);
        settle_idle();
        @(negedge clk);
        cfg_ch.valid          <= 1'b1;
        cfg_ch.quantum_reload <= ticks;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        reload_ticks = ticks;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Task ids favour the extremes and a small pool so duplicates recur.
    function automatic logic [ID_W-1:0] pick_task_id();
        case ($urandom_range(15))
            0:       return '0;
            1:       return '1;
            2, 3:    return ID_W'($urandom_range(1, 4));
            default: return ID_W'($urandom_range(65535));
        endcase
    endfunction

    task automatic run_random(input int count, input int load_pct, input int exit_pct,
                              input int unused_pct);
        int roll;
        for (int k = 0; k < count; k++)
        begin
            roll = $urandom_range(99);
            if (roll < load_pct)
                send_request(OP_LOAD, pick_task_id());
            else if (roll < load_pct + exit_pct)
                send_request(OP_EXIT, ID_W'($urandom_range(65535)));
            else if (roll < load_pct + exit_pct + unused_pct)
                send_request(OP_UNUSED, ID_W'($urandom_range(65535)));
            else
                send_request(OP_TICK, ID_W'($urandom_range(65535)));
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------

    // Empty-ring behaviour, rejected loads, duplicates and removal of the last task.
    task automatic test_corner_cases();
        set_idling(IDLE_NONE);
        send_request(OP_TICK, 16'h0000);   // tick with nothing loaded
        send_request(OP_EXIT, 16'hFFFF);   // exit with no current task
        send_request(OP_LOAD, 16'h0000);   // zero id is refused
        send_request(OP_UNUSED, 16'h1234); // unused code only reports state
        send_request(OP_LOAD, 16'hFFFF);
        send_request(OP_LOAD, 16'h0001);
        send_request(OP_LOAD, 16'hFFFF);   // duplicate id takes its own slot
        send_request(OP_UNUSED, 16'h0000);
        send_request(OP_EXIT, 16'h0000);   // loaded but nobody current yet
        send_request(OP_TICK, 16'h0000);   // head becomes current
        send_request(OP_TICK, 16'h0000);
        send_request(OP_EXIT, 16'h0000);
        send_request(OP_TICK, 16'h0000);
        send_request(OP_EXIT, 16'h0000);
        send_request(OP_EXIT, 16'h0000);   // last task leaves, ring empties
        send_request(OP_EXIT, 16'h0000);
    endtask

    // Zero reload advances on every tick; full reload keeps the turn.
    task automatic test_quantum_extremes();
        write_quantum(8'd0);
        send_request(OP_LOAD, 16'h5555);
        send_request(OP_LOAD, 16'hAAAA);
        repeat (4) send_request(OP_TICK, 16'h0000);
        write_quantum(8'd255);
        send_request(OP_LOAD, 16'h00FF);
        repeat (3) send_request(OP_TICK, 16'hFF00);
        repeat (4) send_request(OP_EXIT, 16'h0000);
    endtask

    // Fill every slot, overflow it, then empty the ring again.
    task automatic test_table_full();
        write_quantum(8'd2);
        set_idling(IDLE_BOTH);
        repeat (SLOTS + 2) send_request(OP_LOAD, ID_W'($urandom_range(1, 65535)));
        send_request(OP_TICK, 16'h0000);
        repeat (SLOTS + 3)
        begin
            if ($urandom_range(3) == 0)
                send_request(OP_TICK, 16'h0000);
            send_request(OP_EXIT, 16'h0000);
        end
    endtask

    task automatic test_random_traffic();
        write_quantum(8'd3);
        set_idling(IDLE_NONE);
        run_random(320, 35, 20, 5);

        write_quantum(8'd0);
        set_idling(IDLE_SENDER);
        run_random(320, 45, 15, 5);

        write_quantum(8'd255);
        set_idling(IDLE_RECEIVER);
        run_random(240, 30, 20, 5);

        write_quantum(8'd1);
        set_idling(IDLE_BOTH);
        run_random(320, 25, 30, 5);

        write_quantum(QUANT_W'($urandom_range(6)));
        set_idling(IDLE_NONE);
        run_random(300, 40, 15, 3);

        write_quantum(8'd5);
        set_idling(IDLE_BOTH);
        run_random(250, 35, 25, 5);
    endtask

    // Hold results off for a long stretch while requests keep coming, so the
    // block backs up and stalls its request channel.
    task automatic test_result_backpressure();
        write_quantum(8'd2);
        set_idling(IDLE_NONE);
        @(posedge clk);
        hold_off_cycles = 300;
        run_random(40, 35, 20, 5);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n                 = 1'b0;
        req_ch.valid          = 1'b0;
        req_ch.operation      = OP_LOAD;
        req_ch.task_id        = '0;
        res_ch.ready          = 1'b0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.quantum_reload = '0;
        clear_schedule();

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_corner_cases();
        test_quantum_extremes();
        test_table_full();
        test_random_traffic();
        test_result_backpressure();

        // Drain, then leave room for anything stray to show up.
        settle_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("PASS round_robin_task_scheduler");
        else
            $display("FAIL round_robin_task_scheduler");
        $finish;
    end

    // Generous ceiling well above the slowest legal run.
    initial
    begin
        #5_000_000;
        $display("FAIL round_robin_task_scheduler");
        $finish;
    end

endmodule
